>>> hdl/pfs_pkg.sv
package pfs_pkg;

  localparam int MAX_MSG_BYTES_DEF = 65536;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FIELD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_KIND  = 8'd1;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_I32    = 3'd5;

  localparam logic [3:0]  VARINT_MAX_BYTES = 4'd10;
  localparam logic [31:0] SKIP_I32_BYTES   = 32'd4;
  localparam logic [31:0] SKIP_I64_BYTES   = 32'd8;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_LEN,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] field_value;
    logic [15:0] data_offset;
    logic [31:0] data_length;
  } result_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    r = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

endpackage

>>> hdl/pfs_in_if.sv
interface pfs_in_if import pfs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last;

  modport source (output valid, output msg_byte, output last, input ready);
  modport sink (input valid, input msg_byte, input last, output ready);
endinterface

>>> hdl/pfs_out_if.sv
interface pfs_out_if import pfs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] field_value;
  logic [15:0] data_offset;
  logic [31:0] data_length;

  modport source (output valid, output found, output field_value, output data_offset,
                  output data_length, input ready);
  modport sink (input valid, input found, input field_value, input data_offset,
                input data_length, output ready);
endinterface

>>> hdl/pfs_cfg_if.sv
interface pfs_cfg_if import pfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hdl/pfs_in_stage.sv
module pfs_in_stage import pfs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pfs_in_if.sink       in_ch,
  input  logic         item_take,
  output logic         item_valid,
  output item_t        item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_ch.ready = !valid_r || item_take;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load ? 1'b1 : (item_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.msg_byte <= in_ch.msg_byte;
      item_r.last     <= in_ch.last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> hdl/pfs_scan.sv
module pfs_scan import pfs_pkg::*; #(
  parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  pfs_cfg_if.sink cfg_ch,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    out_free,
  output logic    item_take,
  output logic    res_valid,
  output result_t res
);

  localparam int          CAP_INT = (MAX_MSG_BYTES - 1 > 65535) ? 65535 : MAX_MSG_BYTES - 1;
  localparam logic [15:0] POS_CAP = 16'(CAP_INT);

  logic [7:0]  target_field_r;
  logic        target_kind_r;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        match_r, match_nxt;

  logic [7:0]  b;
  logic [63:0] ext;
  logic [5:0]  sh_amt;
  logic [63:0] acc_new;
  logic [3:0]  cnt_inc;
  logic        vi_done, vi_bad;
  logic [15:0] pos_next;
  logic [2:0]  tag_wt;
  logic [7:0]  tag_fn;
  logic        tag_match;
  logic [31:0] len_sat;
  logic [31:0] skip_dec;
  logic        step_fail, step_hit, emit;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_field_r <= 8'd1;
      target_kind_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.reg_index == REG_TARGET_FIELD) begin
        target_field_r <= cfg_ch.wdata;
      end else if (cfg_ch.reg_index == REG_TARGET_KIND) begin
        target_kind_r <= cfg_ch.wdata[0];
      end
    end
  end

  // varint byte step
  assign b       = item.msg_byte;
  assign ext     = {57'd0, b[6:0]};
  assign sh_amt  = 6'(7 * int'(cnt_r));
  assign acc_new = acc_r | ((cnt_r < VARINT_MAX_BYTES) ? (ext << sh_amt) : 64'd0);
  assign cnt_inc = cnt_r + 4'd1;
  assign vi_done = !b[7];
  assign vi_bad  = b[7] && (cnt_inc >= VARINT_MAX_BYTES);

  assign pos_next  = (pos_r < POS_CAP) ? pos_r + 16'd1 : POS_CAP;
  assign tag_wt    = acc_new[2:0];
  assign tag_fn    = acc_new[10:3];
  assign tag_match = (tag_fn == target_field_r) &&
                     (tag_wt == (target_kind_r ? WT_LEN : WT_VARINT));
  assign len_sat   = sat32(acc_new);
  assign skip_dec  = (skip_r != 32'd0) ? skip_r - 32'd1 : skip_r;

  always_comb begin
    step_fail = 1'b0;
    step_hit  = 1'b0;
    res       = '0;
    case (phase_r)
      PH_TAG: begin
        if (vi_bad) begin
          step_fail = 1'b1;
        end else if (vi_done && !(tag_wt inside {WT_VARINT, WT_I64, WT_LEN, WT_I32})) begin
          step_fail = 1'b1;
        end
      end
      PH_VARINT: begin
        if (vi_bad) begin
          step_fail = 1'b1;
        end else if (vi_done && match_r) begin
          step_hit        = 1'b1;
          res.found       = 1'b1;
          res.field_value = acc_new;
        end
      end
      PH_LEN: begin
        if (vi_bad) begin
          step_fail = 1'b1;
        end else if (vi_done && match_r) begin
          step_hit        = 1'b1;
          res.found       = 1'b1;
          res.data_offset = pos_next;
          res.data_length = len_sat;
        end
      end
      default: ;
    endcase
    emit      = step_fail || step_hit || (item.last && phase_r != PH_DONE);
    item_take = item_valid && (!emit || out_free);
    res_valid = item_valid && emit && out_free;
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    match_nxt = match_r;
    if (item_take) begin
      case (phase_r)
        PH_TAG: begin
          acc_nxt = acc_new;
          cnt_nxt = cnt_inc;
          if (!vi_bad && vi_done) begin
            match_nxt = tag_match;
            acc_nxt   = 64'd0;
            cnt_nxt   = 4'd0;
            case (tag_wt)
              WT_VARINT: phase_nxt = PH_VARINT;
              WT_LEN:    phase_nxt = PH_LEN;
              WT_I32: begin
                skip_nxt  = SKIP_I32_BYTES;
                phase_nxt = PH_SKIP;
              end
              WT_I64: begin
                skip_nxt  = SKIP_I64_BYTES;
                phase_nxt = PH_SKIP;
              end
              default: ;
            endcase
          end
        end
        PH_VARINT: begin
          acc_nxt = acc_new;
          cnt_nxt = cnt_inc;
          if (!vi_bad && vi_done) begin
            if (!match_r) begin
              phase_nxt = PH_TAG;
            end
            acc_nxt = 64'd0;
            cnt_nxt = 4'd0;
          end
        end
        PH_LEN: begin
          acc_nxt = acc_new;
          cnt_nxt = cnt_inc;
          if (!vi_bad && vi_done) begin
            if (!match_r) begin
              skip_nxt  = len_sat;
              phase_nxt = (len_sat == 32'd0) ? PH_TAG : PH_SKIP;
            end
            acc_nxt = 64'd0;
            cnt_nxt = 4'd0;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_nxt = PH_TAG;
          end
        end
        default: ;
      endcase
      if (step_fail || step_hit) begin
        phase_nxt = PH_DONE;
      end
      pos_nxt = pos_next;
      if (item.last) begin
        phase_nxt = PH_TAG;
        acc_nxt   = 64'd0;
        cnt_nxt   = 4'd0;
        pos_nxt   = 16'd0;
        skip_nxt  = 32'd0;
        match_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= 64'd0;
      cnt_r   <= 4'd0;
      pos_r   <= 16'd0;
      skip_r  <= 32'd0;
      match_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

>>> hdl/pfs_out_stage.sv
module pfs_out_stage import pfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_valid,
  input  result_t  res,
  output logic     out_free,
  pfs_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free  = !valid_r || out_ch.ready;
  assign valid_nxt = res_valid ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.found       = res_r.found;
  assign out_ch.field_value = res_r.field_value;
  assign out_ch.data_offset = res_r.data_offset;
  assign out_ch.data_length = res_r.data_length;

endmodule

>>> hdl/protobuf_field_scanner_top.sv
// Path: a byte's transaction loads the input register, which feeds the scan logic; the scan
//   logic loads the result register once it is free; at most one result per message.
// Throughput: one byte per cycle; a byte that emits a result (deciding, or a message's last)
//   waits in the input register while the result register holds an unaccepted transaction.
// Reset: synchronous, active-low rst_n; clears scan state, valid flags and sets
//   target_field = 1, target_kind = 0.
module protobuf_field_scanner_top import pfs_pkg::*; #(
  parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pfs_in_if.sink    in_ch,
  pfs_out_if.source out_ch,
  pfs_cfg_if.sink   cfg_ch
);

  logic    item_valid;
  item_t   item;
  logic    item_take;
  logic    out_free;
  logic    res_valid;
  result_t res;

  pfs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  pfs_scan #(
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  pfs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_ch    (out_ch)
  );

endmodule

>>> dv/protobuf_field_scanner_top_tb.sv
`timescale 1ns / 100ps

import pfs_pkg::*;

class field_scan_scoreboard;
  logic [7:0]  tgt_field;
  logic        tgt_kind;
  phase_t      phase;
  logic [63:0] acc;
  logic [3:0]  acc_cnt;
  logic [15:0] pos;
  logic [15:0] pos_cap;
  logic [31:0] skip_left;
  logic [2:0]  wkind;
  logic        hit;
  logic        decided;
  result_t     due_results[$];
  int unsigned err_count;
  int unsigned n_found;
  int unsigned n_absent;

  function new();
    int cap;
    cap = (MAX_MSG_BYTES_DEF - 1 > 'hFFFF) ? 'hFFFF : MAX_MSG_BYTES_DEF - 1;
    pos_cap = cap[15:0];
    tgt_field = 8'd1;
    tgt_kind = 1'b0;
    err_count = 0;
    n_found = 0;
    n_absent = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    phase = PH_TAG;
    acc = '0;
    acc_cnt = '0;
    pos = '0;
    skip_left = '0;
    wkind = '0;
    hit = 1'b0;
    decided = 1'b0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARGET_FIELD: tgt_field = data;
      REG_TARGET_KIND:  tgt_kind = data[0];
      default: ;
    endcase
  endfunction

  // 1: varint complete, 0: more bytes follow, -1: continuation on the tenth byte
  function int take_varint(logic [7:0] b);
    int unsigned sh;
    sh = 7 * acc_cnt;
    if (sh < 64) acc |= {57'd0, b[6:0]} << sh;
    acc_cnt++;
    if (!b[7]) return 1;
    if (acc_cnt >= VARINT_MAX_BYTES) return -1;
    return 0;
  endfunction

  function void note_byte(logic [7:0] b, logic is_last);
    logic [15:0] nxt;
    int          r;
    logic        decide;
    result_t     res;
    res = '0;
    decide = 1'b0;
    nxt = (pos < pos_cap) ? pos + 16'd1 : pos_cap;
    case (phase)
      PH_TAG: begin
        r = take_varint(b);
        if (r < 0) begin
          decide = 1'b1;
        end else if (r > 0) begin
          wkind = acc[2:0];
          hit = (acc[10:3] == tgt_field) && (wkind == (tgt_kind ? WT_LEN : WT_VARINT));
          acc = '0;
          acc_cnt = '0;
          case (wkind)
            WT_VARINT: phase = PH_VARINT;
            WT_LEN: phase = PH_LEN;
            WT_I32: begin
              skip_left = SKIP_I32_BYTES;
              phase = PH_SKIP;
            end
            WT_I64: begin
              skip_left = SKIP_I64_BYTES;
              phase = PH_SKIP;
            end
            default: decide = 1'b1;
          endcase
        end
      end
      PH_VARINT: begin
        r = take_varint(b);
        if (r < 0) begin
          decide = 1'b1;
        end else if (r > 0) begin
          if (hit) begin
            decide = 1'b1;
            res.found = 1'b1;
            res.field_value = acc;
          end else begin
            phase = PH_TAG;
          end
          acc = '0;
          acc_cnt = '0;
        end
      end
      PH_LEN: begin
        r = take_varint(b);
        if (r < 0) begin
          decide = 1'b1;
        end else if (r > 0) begin
          if (hit) begin
            decide = 1'b1;
            res.found = 1'b1;
            res.data_offset = nxt;
            res.data_length = (acc[63:32] != 32'd0) ? 32'hFFFF_FFFF : acc[31:0];
          end else begin
            skip_left = (acc[63:32] != 32'd0) ? 32'hFFFF_FFFF : acc[31:0];
            phase = (skip_left == 32'd0) ? PH_TAG : PH_SKIP;
          end
          acc = '0;
          acc_cnt = '0;
        end
      end
      PH_SKIP: begin
        if (skip_left != 32'd0) skip_left--;
        if (skip_left == 32'd0) phase = PH_TAG;
      end
      default: ;
    endcase
    if (decide) begin
      decided = 1'b1;
      phase = PH_DONE;
      due_results.push_back(res);
    end
    pos = nxt;
    if (is_last) begin
      if (!decided) due_results.push_back('0);
      clear_scan();
    end
  endfunction

  task report(string what);
    $display("ERROR: %s", what);
    err_count++;
  endtask

  task check_result(result_t got);
    result_t exp;
    if (due_results.size() == 0) begin
      report($sformatf("result with nothing pending: found=%0b value=%h off=%h len=%h",
                       got.found, got.field_value, got.data_offset, got.data_length));
      return;
    end
    exp = due_results.pop_front();
    if (exp.found) n_found++;
    else n_absent++;
    if (got.found !== exp.found)
      report($sformatf("found: got %0b, expected %0b", got.found, exp.found));
    if (got.field_value !== exp.field_value)
      report($sformatf("field_value: got %h, expected %h", got.field_value, exp.field_value));
    if (got.data_offset !== exp.data_offset)
      report($sformatf("data_offset: got %h, expected %h", got.data_offset, exp.data_offset));
    if (got.data_length !== exp.data_length)
      report($sformatf("data_length: got %h, expected %h", got.data_length, exp.data_length));
  endtask
endclass

module protobuf_field_scanner_top_tb;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1600;
  localparam int N_PHASES     = 8;

  localparam logic KIND_VARINT = 1'b0;
  localparam logic KIND_BYTES  = 1'b1;

  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_RSVD6  = 3'd6;
  localparam logic [2:0] WT_RSVD7  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        gaps_on;
  logic [7:0]  cur_field;
  logic [7:0]  msg_q[$];
  int unsigned idle_cycles = 0;
  int unsigned n_msgs;
  int unsigned n_bytes;
  int unsigned n_cfg_writes;

  field_scan_scoreboard sb;

  pfs_in_if  in_ch();
  pfs_out_if out_ch();
  pfs_cfg_if cfg_ch();

  protobuf_field_scanner_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
      $display("protobuf_field_scanner_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result({out_ch.found, out_ch.field_value, out_ch.data_offset,
                       out_ch.data_length});
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.msg_byte <= b;
    in_ch.last <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, is_last);
    n_bytes++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    n_msgs++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // early decisions leave bytes in flight with no result; give them time to retire
  task automatic wait_results();
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
    n_cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] field, input logic kind);
    hold_input();
    wait_results();
    write_reg(REG_TARGET_FIELD, field);
    write_reg(REG_TARGET_KIND, {7'd0, kind});
    cur_field = field;
  endtask

  function automatic void put_random_bytes(int n);
    logic [7:0] rb;
    repeat (n) begin
      rb = 8'($urandom_range(0, 255));
      msg_q.push_back(rb);
    end
  endfunction

  function automatic void put_varint_n(logic [63:0] v, int n);
    logic cont;
    for (int i = 0; i < n; i++) begin
      cont = (i < n - 1);
      msg_q.push_back({cont, v[6:0]});
      v = v >> 7;
    end
  endfunction

  function automatic int varint_len(logic [63:0] v);
    int n;
    n = 1;
    while (v > 64'd127) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  function automatic void put_varint(logic [63:0] v);
    put_varint_n(v, varint_len(v));
  endfunction

  function automatic logic [63:0] tag_of(int unsigned fn, logic [2:0] wt);
    return {29'd0, fn, wt};
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: v = v & 64'h7F;
      1: v = v & 64'h3FFF;
      2: v = v >> $urandom_range(0, 63);
      3: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic void put_value_varint();
    logic [63:0] v;
    logic [6:0]  hi;
    v = rand_value();
    case ($urandom_range(0, 9))
      0: put_varint_n(v, $urandom_range(11, 13));
      1: begin
        // tenth byte carries bits beyond 64
        put_varint_n(v, 10);
        hi = 7'($urandom_range(0, 127));
        msg_q[msg_q.size() - 1] = {1'b0, hi};
      end
      2: put_varint_n(v, varint_len(v) + $urandom_range(1, 3));
      default: put_varint(v);
    endcase
  endfunction

  function automatic void put_field(int unsigned fn, logic [2:0] wt);
    logic [63:0] len;
    int          n;
    if ($urandom_range(0, 39) == 0) put_varint_n(tag_of(fn, wt), 11);
    else put_varint(tag_of(fn, wt));
    case (wt)
      WT_VARINT: put_value_varint();
      WT_LEN: begin
        if ($urandom_range(0, 7) == 0) begin
          // declared length far past the message end, may exceed 32 bits
          len = {$urandom, $urandom} >> $urandom_range(0, 40);
          put_varint(len);
        end else begin
          n = $urandom_range(0, 6);
          len = 64'(n);
          if ($urandom_range(0, 7) == 0) put_varint_n(len, 2);
          else put_varint(len);
          put_random_bytes(n);
        end
      end
      WT_I32: put_random_bytes(4);
      WT_I64: put_random_bytes(8);
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] pick_wire_type();
    int r;
    r = $urandom_range(0, 15);
    if (r < 6) return WT_VARINT;
    if (r < 11) return WT_LEN;
    if (r < 13) return WT_I32;
    if (r < 15) return WT_I64;
    case ($urandom_range(0, 3))
      0: return WT_SGROUP;
      1: return WT_EGROUP;
      2: return WT_RSVD6;
      default: return WT_RSVD7;
    endcase
  endfunction

  function automatic int unsigned pick_field_num();
    int unsigned fn;
    case ($urandom_range(0, 3))
      0, 1: begin
        fn = 32'(cur_field);
        // same low 8 bits, higher field number
        if ($urandom_range(0, 3) == 0) fn += 256 * $urandom_range(1, 3);
      end
      2: fn = $urandom_range(0, 255);
      default: fn = $urandom_range(0, 4095);
    endcase
    return fn;
  endfunction

  function automatic void gen_message();
    int cut;
    msg_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      put_random_bytes($urandom_range(1, 8));
      return;
    end
    repeat ($urandom_range(1, 4)) put_field(pick_field_num(), pick_wire_type());
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
  endfunction

  initial begin
    int unsigned start;
    logic [7:0]  field;
    sb = new();
    rst_n = 1'b0;
    gaps_on = 1'b1;
    cur_field = 8'd1;
    n_msgs = 0;
    n_bytes = 0;
    n_cfg_writes = 0;
    in_ch.valid = 1'b0;
    in_ch.msg_byte = '0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config: field 1, varint
    msg_q = '{8'h08, 8'h96, 8'h01};
    send_msg();
    msg_q = '{8'hFF};
    send_msg();
    msg_q = '{8'h00, 8'h00};
    send_msg();
    // group wire type is malformed; bytes after it are ignored
    msg_q = '{8'h0B, 8'h08, 8'h01};
    send_msg();
    msg_q = '{8'h0D, 8'h01, 8'h02, 8'h03, 8'h04, 8'h08, 8'h7F};
    send_msg();
    configure(8'd1, KIND_BYTES);
    msg_q = '{8'h0A, 8'h02, 8'hAA, 8'h55};
    send_msg();
    msg_q = '{8'h08, 8'h05, 8'h0A, 8'h00};
    send_msg();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: configure(8'd0, KIND_VARINT);
        1: configure(8'hFF, KIND_BYTES);
        default: begin
          field = 8'($urandom_range(0, 255));
          configure(field, p[0]);
        end
      endcase
      gaps_on = (p % 4 != 3);
      start = n_bytes;
      while (n_bytes - start < RANDOM_BYTES / N_PHASES) begin
        gen_message();
        send_msg();
      end
    end

    hold_input();
    wait_results();
    $display("run covered %0d messages, %0d bytes, %0d register writes",
             n_msgs, n_bytes, n_cfg_writes);
    $display("results checked: %0d with a match, %0d without", sb.n_found, sb.n_absent);
    if (sb.err_count == 0) begin
      $display("protobuf_field_scanner_top_tb: done, clean");
    end else begin
      $display("protobuf_field_scanner_top_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pfs_pkg.sv
hdl/pfs_in_if.sv
hdl/pfs_out_if.sv
hdl/pfs_cfg_if.sv
hdl/pfs_in_stage.sv
hdl/pfs_scan.sv
hdl/pfs_out_stage.sv
hdl/protobuf_field_scanner_top.sv
dv/protobuf_field_scanner_top_tb.sv
